>>> sv/cvmr_pkg.sv
// shared types and constants of the validity mask reducer
// used by every module of the block, no dependencies
`default_nettype none
package cvmr_pkg;
    localparam int MASK_COLS = 512;
    localparam int MASK_ROWS = 512;
    localparam int COL_W = (MASK_COLS > 1) ? $clog2(MASK_COLS) : 1;
    localparam int ROW_W = (MASK_ROWS > 1) ? $clog2(MASK_ROWS) : 1;
    localparam int XC_W = $clog2(MASK_COLS + 1);
    localparam int YC_W = $clog2(MASK_ROWS + 1);
    localparam int QDEPTH = 4;
    localparam int Q_W = $clog2(QDEPTH);
    localparam logic [15:0] UNMAPPED = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_FOOT = 2'd1,
        OP_REMAP = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_MAP_W = 3'd2,
        REG_MAP_H = 3'd3,
        REG_SRC_W = 3'd4,
        REG_SRC_H = 3'd5,
        REG_SCALE_X = 3'd6,
        REG_SCALE_Y = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        K_FILL,
        K_FOOT,
        K_RECT,
        K_READ
    } t_kind;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_RD,
        S_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [24:0] offset_x;
        logic [24:0] offset_y;
        logic [16:0] map_width;
        logic [16:0] map_height;
        logic [15:0] source_width;
        logic [15:0] source_height;
        logic [24:0] scale_x;
        logic [24:0] scale_y;
    } t_cfg;

    typedef struct packed {
        logic [15:0] map_y;
        logic [15:0] map_x;
        logic [15:0] row;
        logic [15:0] col;
        t_op         op;
    } t_item;

    typedef struct packed {
        t_kind            kind;
        logic             oor;
        logic [XC_W-1:0]  x0;
        logic [XC_W-1:0]  x1;
        logic [YC_W-1:0]  y0;
        logic [YC_W-1:0]  y1;
    } t_cmd;
endpackage
`default_nettype wire

>>> sv/conservative_validity_mask_reducer.sv
// top level of the validity mask reducer: config registers, front, queue, back
// depends on cvmr_pkg, cvmr_front, cvmr_queue, cvmr_back
`default_nettype none
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: op, col, row, map_x, map_y
// m_*       out  m_tvalid/m_tready  m_tdata: cell_valid
// apb       in   psel/penable/...   8 registers at byte address 4*index
//
// the mask is a memory of MASK_ROWS words of MASK_COLS bits, one row per cycle
// the back pops each command while idle, then:
// clear: writes every row; footprint: reads then writes every row
// remap pixel: reads then writes each mask row touched; read cell: reads its row, waits under m_tready stall
// front end registers each item in its operand and product stages and runs ahead through a 4-entry queue
// after reset a fill pass sets every cell, s_tready low meanwhile
module conservative_validity_mask_reducer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // op[1:0] col[17:2] row[33:18] map_x[49:34] map_y[65:50]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // cell_valid[0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    cvmr_pkg::t_cfg  r_cfg;
    cvmr_pkg::t_item item;
    cvmr_pkg::t_cmd  f_cmd, q_cmd;
    cvmr_pkg::t_reg  addr;
    logic            push, full, pop, empty, init, obit;

    assign pready = 1'b1;
    assign addr = cvmr_pkg::t_reg'(paddr[4:2]);
    assign item = s_tdata[65:0];

    // register file, written on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x <= '0;
            r_cfg.offset_y <= '0;
            r_cfg.map_width <= 17'd1;
            r_cfg.map_height <= 17'd1;
            r_cfg.source_width <= 16'd1;
            r_cfg.source_height <= 16'd1;
            r_cfg.scale_x <= 25'h1000000;
            r_cfg.scale_y <= 25'h1000000;
        end else if (psel && penable && pwrite) begin
            case (addr)
                cvmr_pkg::REG_OFFSET_X: r_cfg.offset_x <= pwdata[24:0];
                cvmr_pkg::REG_OFFSET_Y: r_cfg.offset_y <= pwdata[24:0];
                cvmr_pkg::REG_MAP_W: r_cfg.map_width <= pwdata[16:0];
                cvmr_pkg::REG_MAP_H: r_cfg.map_height <= pwdata[16:0];
                cvmr_pkg::REG_SRC_W: r_cfg.source_width <= pwdata[15:0];
                cvmr_pkg::REG_SRC_H: r_cfg.source_height <= pwdata[15:0];
                cvmr_pkg::REG_SCALE_X: r_cfg.scale_x <= pwdata[24:0];
                cvmr_pkg::REG_SCALE_Y: r_cfg.scale_y <= pwdata[24:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (addr)
            cvmr_pkg::REG_OFFSET_X: prdata = {7'b0, r_cfg.offset_x};
            cvmr_pkg::REG_OFFSET_Y: prdata = {7'b0, r_cfg.offset_y};
            cvmr_pkg::REG_MAP_W: prdata = {15'b0, r_cfg.map_width};
            cvmr_pkg::REG_MAP_H: prdata = {15'b0, r_cfg.map_height};
            cvmr_pkg::REG_SRC_W: prdata = {16'b0, r_cfg.source_width};
            cvmr_pkg::REG_SRC_H: prdata = {16'b0, r_cfg.source_height};
            cvmr_pkg::REG_SCALE_X: prdata = {7'b0, r_cfg.scale_x};
            cvmr_pkg::REG_SCALE_Y: prdata = {7'b0, r_cfg.scale_y};
            default: prdata = '0;
        endcase
    end

    cvmr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_tvalid), .o_ready(s_tready), .i_item(item), .i_cfg(r_cfg),
        .i_en(!init), .i_full(full), .o_push(push), .o_cmd(f_cmd)
    );

    cvmr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cmd(f_cmd), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_cmd(q_cmd)
    );

    cvmr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_cmd(q_cmd), .o_pop(pop), .o_init(init),
        .o_valid(m_tvalid), .i_ready(m_tready), .o_bit(obit)
    );

    assign m_tdata = {7'b0, obit};
endmodule
`default_nettype wire

>>> sv/cvmr_front.sv
// front end: accepts items, computes fixed-point footprints, emits commands
// depends on cvmr_pkg
`default_nettype none
module cvmr_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire cvmr_pkg::t_item i_item,
    input  wire cvmr_pkg::t_cfg  i_cfg,
    input  wire logic           i_en,
    input  wire logic           i_full,
    output logic                o_push,
    output cvmr_pkg::t_cmd      o_cmd
);
    logic            r_v1, r_keep1;
    cvmr_pkg::t_op   r_op1;
    logic [25:0]     r_ax, r_bx, r_ay, r_by;
    logic [15:0]     r_col1, r_row1;
    logic            r_v2, r_keep2;
    cvmr_pkg::t_op   r_op2;
    logic [50:0]     r_pxa, r_pxb, r_pya, r_pyb;
    logic [15:0]     r_col2, r_row2;
    logic            adv1, adv2, discard, acc;
    logic [25:0]     n_ax, n_bx, n_ay, n_by;
    logic            n_keep, bad_map;

    function automatic logic [19:0] fl(input logic [50:0] p);
        return {1'b0, p[50:32]};
    endfunction
    function automatic logic [19:0] ce(input logic [50:0] p);
        logic [51:0] s;
        s = {1'b0, p} + 52'hFFFFFFFF;
        return s[51:32];
    endfunction
    function automatic logic [cvmr_pkg::XC_W-1:0] clx(input logic [19:0] v);
        if (v > 20'(cvmr_pkg::MASK_COLS)) return cvmr_pkg::XC_W'(cvmr_pkg::MASK_COLS);
        return v[cvmr_pkg::XC_W-1:0];
    endfunction
    function automatic logic [cvmr_pkg::YC_W-1:0] cly(input logic [19:0] v);
        if (v > 20'(cvmr_pkg::MASK_ROWS)) return cvmr_pkg::YC_W'(cvmr_pkg::MASK_ROWS);
        return v[cvmr_pkg::YC_W-1:0];
    endfunction

    // operand build: placement alone for op 1, pixel edges for every other op
    always_comb begin
        bad_map = i_item.map_x == cvmr_pkg::UNMAPPED || i_item.map_y == cvmr_pkg::UNMAPPED
               || i_item.map_x >= i_cfg.source_width || i_item.map_y >= i_cfg.source_height;
        if (i_item.op == cvmr_pkg::OP_FOOT) begin
            n_ax = {1'b0, i_cfg.offset_x};
            n_bx = {1'b0, i_cfg.offset_x} + {1'b0, i_cfg.map_width, 8'b0};
            n_ay = {1'b0, i_cfg.offset_y};
            n_by = {1'b0, i_cfg.offset_y} + {1'b0, i_cfg.map_height, 8'b0};
        end else begin
            n_ax = {1'b0, i_cfg.offset_x} + {2'b0, i_item.col, 8'b0};
            n_bx = {1'b0, i_cfg.offset_x} + {1'b0, {1'b0, i_item.col} + 17'd1, 8'b0};
            n_ay = {1'b0, i_cfg.offset_y} + {2'b0, i_item.row, 8'b0};
            n_by = {1'b0, i_cfg.offset_y} + {1'b0, {1'b0, i_item.row} + 17'd1, 8'b0};
        end
        n_keep = 1'b1;
        if (i_item.op == cvmr_pkg::OP_REMAP)
            n_keep = bad_map && ({1'b0, i_item.col} < i_cfg.map_width)
                  && ({1'b0, i_item.row} < i_cfg.map_height);
    end

    // command build from registered products
    always_comb begin
        o_cmd = '0;
        o_cmd.oor = 1'b0;
        case (r_op2)
            cvmr_pkg::OP_CLEAR: o_cmd.kind = cvmr_pkg::K_FILL;
            cvmr_pkg::OP_FOOT: begin
                o_cmd.kind = cvmr_pkg::K_FOOT;
                o_cmd.x0 = clx(ce(r_pxa));
                o_cmd.x1 = clx(fl(r_pxb));
                o_cmd.y0 = cly(ce(r_pya));
                o_cmd.y1 = cly(fl(r_pyb));
            end
            cvmr_pkg::OP_REMAP: begin
                o_cmd.kind = cvmr_pkg::K_RECT;
                o_cmd.x0 = clx(fl(r_pxa));
                o_cmd.x1 = clx(ce(r_pxb));
                o_cmd.y0 = cly(fl(r_pya));
                o_cmd.y1 = cly(ce(r_pyb));
            end
            default: begin
                o_cmd.kind = cvmr_pkg::K_READ;
                o_cmd.oor = (r_col2 >= 16'(cvmr_pkg::MASK_COLS))
                         || (r_row2 >= 16'(cvmr_pkg::MASK_ROWS));
                o_cmd.x0 = cvmr_pkg::XC_W'(r_col2[cvmr_pkg::COL_W-1:0]);
                o_cmd.y0 = cvmr_pkg::YC_W'(r_row2[cvmr_pkg::ROW_W-1:0]);
            end
        endcase
        discard = !r_keep2 || (r_op2 == cvmr_pkg::OP_REMAP
                  && (o_cmd.x1 <= o_cmd.x0 || o_cmd.y1 <= o_cmd.y0));
        o_push = r_v2 && !discard && !i_full;
        adv2 = !r_v2 || discard || !i_full;
        adv1 = !r_v1 || adv2;
        o_ready = adv1 && i_en;
        acc = i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= acc;
            if (adv2) r_v2 <= r_v1;
        end
        if (adv1) begin
            r_op1 <= i_item.op;
            r_ax <= n_ax;
            r_bx <= n_bx;
            r_ay <= n_ay;
            r_by <= n_by;
            r_keep1 <= n_keep;
            r_col1 <= i_item.col;
            r_row1 <= i_item.row;
        end
        if (adv2) begin
            r_op2 <= r_op1;
            r_pxa <= r_ax * i_cfg.scale_x;
            r_pxb <= r_bx * i_cfg.scale_x;
            r_pya <= r_ay * i_cfg.scale_y;
            r_pyb <= r_by * i_cfg.scale_y;
            r_keep2 <= r_keep1;
            r_col2 <= r_col1;
            r_row2 <= r_row1;
        end
    end
endmodule
`default_nettype wire

>>> sv/cvmr_queue.sv
// short command queue between front end and mask sequencer
// depends on cvmr_pkg
`default_nettype none
module cvmr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire cvmr_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output cvmr_pkg::t_cmd      o_cmd
);
    cvmr_pkg::t_cmd            r_mem [cvmr_pkg::QDEPTH];
    logic [cvmr_pkg::Q_W-1:0]  r_wp, r_rp;
    logic [cvmr_pkg::Q_W:0]    r_cnt;

    assign o_full = r_cnt == (cvmr_pkg::Q_W+1)'(cvmr_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

>>> sv/cvmr_back.sv
// mask sequencer: row-wide validity memory, read-modify-write per row
// depends on cvmr_pkg
`default_nettype none
module cvmr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire cvmr_pkg::t_cmd i_cmd,
    output logic                o_pop,
    output logic                o_init,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_bit
);
    logic [cvmr_pkg::MASK_COLS-1:0] r_mem [cvmr_pkg::MASK_ROWS];
    logic [cvmr_pkg::MASK_COLS-1:0] r_rdata, wdata, span;
    cvmr_pkg::t_state               r_state, n_state;
    cvmr_pkg::t_cmd                 r_cmd;
    logic [cvmr_pkg::YC_W-1:0]      r_row, n_row, r_end, n_end, row_nx;
    logic                           r_init, rd_en, we, row_in, load_out;
    logic                           r_ov, r_obit;

    always_comb begin
        for (int c = 0; c < cvmr_pkg::MASK_COLS; c++)
            span[c] = (cvmr_pkg::XC_W'(c) >= r_cmd.x0) && (cvmr_pkg::XC_W'(c) < r_cmd.x1);
        row_in = (r_row >= r_cmd.y0) && (r_row < r_cmd.y1);
        if (r_state == cvmr_pkg::S_FILL) wdata = '1;
        else if (r_cmd.kind == cvmr_pkg::K_FOOT) wdata = row_in ? (r_rdata & span) : '0;
        else wdata = r_rdata & ~span;
    end

    always_comb begin
        n_state = r_state;
        n_row = r_row;
        n_end = r_end;
        row_nx = r_row + 1'b1;
        o_pop = 1'b0;
        rd_en = 1'b0;
        we = 1'b0;
        load_out = 1'b0;
        case (r_state)
            cvmr_pkg::S_FILL: begin
                we = 1'b1;
                n_row = row_nx;
                if (row_nx == r_end) n_state = cvmr_pkg::S_IDLE;
            end
            cvmr_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        cvmr_pkg::K_FILL: begin
                            n_row = '0;
                            n_end = cvmr_pkg::YC_W'(cvmr_pkg::MASK_ROWS);
                            n_state = cvmr_pkg::S_FILL;
                        end
                        cvmr_pkg::K_FOOT: begin
                            n_row = '0;
                            n_end = cvmr_pkg::YC_W'(cvmr_pkg::MASK_ROWS);
                            n_state = cvmr_pkg::S_RD;
                        end
                        cvmr_pkg::K_RECT: begin
                            n_row = i_cmd.y0;
                            n_end = i_cmd.y1;
                            n_state = cvmr_pkg::S_RD;
                        end
                        default: begin
                            n_row = i_cmd.y0;
                            n_state = i_cmd.oor ? cvmr_pkg::S_OUT : cvmr_pkg::S_RD;
                        end
                    endcase
                end
            end
            cvmr_pkg::S_RD: begin
                rd_en = 1'b1;
                n_state = (r_cmd.kind == cvmr_pkg::K_READ) ? cvmr_pkg::S_OUT : cvmr_pkg::S_WR;
            end
            cvmr_pkg::S_WR: begin
                we = 1'b1;
                n_row = row_nx;
                n_state = (row_nx == r_end) ? cvmr_pkg::S_IDLE : cvmr_pkg::S_RD;
            end
            cvmr_pkg::S_OUT: begin
                if (!r_ov || i_ready) begin
                    load_out = 1'b1;
                    n_state = cvmr_pkg::S_IDLE;
                end
            end
            default: n_state = cvmr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvmr_pkg::S_FILL;
            r_row <= '0;
            r_end <= cvmr_pkg::YC_W'(cvmr_pkg::MASK_ROWS);
            r_init <= 1'b1;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row <= n_row;
            r_end <= n_end;
            if (r_state == cvmr_pkg::S_FILL && n_state == cvmr_pkg::S_IDLE) r_init <= 1'b0;
            if (load_out) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
        if (o_pop) r_cmd <= i_cmd;
        if (load_out)
            r_obit <= r_cmd.oor ? 1'b0 : r_rdata[r_cmd.x0[cvmr_pkg::COL_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rdata <= r_mem[r_row[cvmr_pkg::ROW_W-1:0]];
        if (we) r_mem[r_row[cvmr_pkg::ROW_W-1:0]] <= wdata;
    end

    assign o_init = r_init;
    assign o_valid = r_ov;
    assign o_bit = r_obit;
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the conservative validity mask reducer
// depends on cvmr_pkg and conservative_validity_mask_reducer; mask predictor held locally
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cvmr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // op[1:0] col[17:2] row[33:18] map_x[49:34] map_y[65:50]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // cell_valid[0]
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    conservative_validity_mask_reducer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // settle time after the last result: a queue full of footprint passes
    localparam int DRAIN_CYCLES = 6000;

    // predictor state: mask copy and register copy
    logic [MASK_COLS-1:0] mask_rows [MASK_ROWS];
    t_cfg                 cur_cfg;

    bit   valid_expected [$];
    int   fails = 0;
    int   reads_checked = 0;
    int   remaps_sent = 0;
    int   passes_sent = 0;
    bit   calm_tx = 1'b0;     // stretches with no idling on the sender
    bit   calm_rx = 1'b0;     // and on the receiver
    int   last_cx = 0, last_cy = 0;

    // ------------------------------------------------------------------
    // mask predictor
    // ------------------------------------------------------------------
    function automatic void mask_fill();
        for (int r = 0; r < MASK_ROWS; r++) mask_rows[r] = '1;
    endfunction

    // clears every cell whose footprint is not fully inside the placement
    function automatic void mask_trim_to_placement();
        longint unsigned ox, oy, sx, sy, px, qx, py, qy;
        bit row_out;
        ox = cur_cfg.offset_x; oy = cur_cfg.offset_y;
        sx = cur_cfg.scale_x;  sy = cur_cfg.scale_y;
        px = ox * sx;
        qx = (ox + (longint'(cur_cfg.map_width) << 8)) * sx;
        py = oy * sy;
        qy = (oy + (longint'(cur_cfg.map_height) << 8)) * sy;
        for (int r = 0; r < MASK_ROWS; r++) begin
            row_out = ((longint'(r) << 32) < py) || ((longint'(r + 1) << 32) > qy);
            for (int c = 0; c < MASK_COLS; c++) begin
                if (row_out || ((longint'(c) << 32) < px) || ((longint'(c + 1) << 32) > qx))
                    mask_rows[r][c] = 1'b0;
            end
        end
    endfunction

    function automatic longint unsigned lim_cells(longint unsigned v, int lim);
        return (v > lim) ? lim : v;
    endfunction

    // one remap pixel: unmapped or out-of-source pixels knock out their cells
    function automatic void mask_remap_pixel(t_item it);
        longint unsigned x0, x1, y0, y1, ox, oy, sx, sy;
        longint unsigned col, row;
        ox = cur_cfg.offset_x; oy = cur_cfg.offset_y;
        sx = cur_cfg.scale_x;  sy = cur_cfg.scale_y;
        col = it.col; row = it.row;
        if (col >= cur_cfg.map_width || row >= cur_cfg.map_height) return;
        if (!(it.map_x == UNMAPPED || it.map_y == UNMAPPED ||
              it.map_x >= cur_cfg.source_width || it.map_y >= cur_cfg.source_height))
            return;
        x0 = lim_cells(((ox + (col << 8)) * sx) >> 32, MASK_COLS);
        x1 = lim_cells((((ox + ((col + 1) << 8)) * sx) + 64'hFFFF_FFFF) >> 32, MASK_COLS);
        y0 = lim_cells(((oy + (row << 8)) * sy) >> 32, MASK_ROWS);
        y1 = lim_cells((((oy + ((row + 1) << 8)) * sy) + 64'hFFFF_FFFF) >> 32, MASK_ROWS);
        if (x1 <= x0) return;
        for (longint unsigned y = y0; y < y1; y++)
            for (longint unsigned x = x0; x < x1; x++)
                mask_rows[y][x] = 1'b0;
        if (y1 > y0) begin
            last_cx = int'(x0);
            last_cy = int'(y0);
        end
    endfunction

    function automatic bit mask_lookup(t_item it);
        if (it.col < MASK_COLS && it.row < MASK_ROWS) return mask_rows[it.row][it.col];
        return 1'b0;
    endfunction

    // advances the predictor for one accepted word; typed value overrides for reads
    function automatic void mask_step(t_item it, bit typed, bit typed_val);
        case (it.op)
            OP_CLEAR: mask_fill();
            OP_FOOT:  mask_trim_to_placement();
            OP_REMAP: mask_remap_pixel(it);
            OP_READ:  valid_expected.push_back(typed ? typed_val : mask_lookup(it));
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_word(t_item it, bit typed, bit typed_val);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, it};
        do @(posedge i_clk); while (!s_tready);
        mask_step(it, typed, typed_val);
        if (it.op == OP_READ) reads_checked++;
        if (it.op == OP_REMAP) remaps_sent++;
        if (it.op == OP_FOOT || it.op == OP_CLEAR) passes_sent++;
    endtask

    task automatic apb_write(t_reg idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_placement(t_cfg c);
        apb_write(REG_OFFSET_X, 32'(c.offset_x));
        apb_write(REG_OFFSET_Y, 32'(c.offset_y));
        apb_write(REG_MAP_W,    32'(c.map_width));
        apb_write(REG_MAP_H,    32'(c.map_height));
        apb_write(REG_SRC_W,    32'(c.source_width));
        apb_write(REG_SRC_H,    32'(c.source_height));
        apb_write(REG_SCALE_X,  32'(c.scale_x));
        apb_write(REG_SCALE_Y,  32'(c.scale_y));
        cur_cfg = c;
    endtask

    // hold the sender until every read has come back
    task automatic drain_reads();
        s_tvalid <= 1'b0;
        while (valid_expected.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (valid_expected.size() == 0) begin
                $error("cell_valid: no word expected, got %0d", m_tdata[0]);
                fails++;
            end else begin
                bit want;
                want = valid_expected.pop_front();
                if (m_tdata[0] !== want) begin
                    $error("cell_valid: expected %0d, got %0d", want, m_tdata[0]);
                    fails++;
                end
            end
        end
    end

    // receiver back-pressure, one draw per word
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = calm_rx ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    typedef struct {
        t_op         op;
        logic [15:0] col, row, mx, my;
        bit          typed;
        bit          val;
    } t_row;

    // directed rows, reset placement: one-pixel plane, one-pixel source, unit scale
    t_row directed [] = '{
        '{OP_READ,  16'd0,     16'd0,     16'd0,     16'd0,     1'b1, 1'b1},
        '{OP_READ,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, 1'b0},
        '{OP_READ,  16'd511,   16'd511,   16'd0,     16'd0,     1'b1, 1'b1},
        '{OP_READ,  16'd512,   16'd0,     16'd0,     16'd0,     1'b1, 1'b0},
        '{OP_READ,  16'd0,     16'd512,   16'd0,     16'd0,     1'b1, 1'b0},
        '{OP_REMAP, 16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b0},
        '{OP_READ,  16'd0,     16'd0,     16'd0,     16'd0,     1'b1, 1'b1},
        '{OP_REMAP, 16'd1,     16'd0,     16'hFFFF,  16'hFFFF,  1'b0, 1'b0},
        '{OP_REMAP, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, 1'b0},
        '{OP_READ,  16'd1,     16'd0,     16'd0,     16'd0,     1'b0, 1'b0},
        '{OP_REMAP, 16'd0,     16'd0,     16'hFFFF,  16'd0,     1'b0, 1'b0},
        '{OP_READ,  16'd0,     16'd0,     16'd0,     16'd0,     1'b1, 1'b0},
        '{OP_CLEAR, 16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b0},
        '{OP_REMAP, 16'd0,     16'd0,     16'd0,     16'hFFFF,  1'b0, 1'b0},
        '{OP_READ,  16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b0},
        '{OP_CLEAR, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, 1'b0},
        '{OP_REMAP, 16'd0,     16'd0,     16'd1,     16'd0,     1'b0, 1'b0},
        '{OP_READ,  16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b0},
        '{OP_CLEAR, 16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b0},
        '{OP_FOOT,  16'd0,     16'd0,     16'd0,     16'd0,     1'b0, 1'b0},
        '{OP_READ,  16'd0,     16'd0,     16'd0,     16'd0,     1'b1, 1'b1},
        '{OP_READ,  16'd1,     16'd0,     16'd0,     16'd0,     1'b1, 1'b0},
        '{OP_READ,  16'd0,     16'd1,     16'd0,     16'd0,     1'b1, 1'b0},
        '{OP_READ,  16'd511,   16'd511,   16'hFFFF,  16'hFFFF,  1'b1, 1'b0}
    };

    // placements walked by the random part, extremes among them
    t_cfg placements [] = '{
        '{offset_x: 25'd0, offset_y: 25'd0, map_width: 17'd4096, map_height: 17'd4096,
          source_width: 16'd3000, source_height: 16'd3000,
          scale_x: 25'd2097152, scale_y: 25'd2097152},
        '{offset_x: 25'd256077, offset_y: 25'd76800, map_width: 17'd2000,
          map_height: 17'd1500, source_width: 16'd65534, source_height: 16'd65534,
          scale_x: 25'd4206649, scale_y: 25'd8388608},
        '{offset_x: 25'd16777216, offset_y: 25'd16777216, map_width: 17'd65536,
          map_height: 17'd65536, source_width: 16'd0, source_height: 16'd0,
          scale_x: 25'd16777216, scale_y: 25'd16777216},
        '{offset_x: 25'd5000, offset_y: 25'd7000, map_width: 17'd800, map_height: 17'd800,
          source_width: 16'd1, source_height: 16'd1, scale_x: 25'd0, scale_y: 25'd0},
        '{offset_x: 25'd0, offset_y: 25'd0, map_width: 17'd600, map_height: 17'd300,
          source_width: 16'd100, source_height: 16'd65534,
          scale_x: 25'd16777216, scale_y: 25'd16777216},
        '{offset_x: 25'd128, offset_y: 25'd25600, map_width: 17'd65536, map_height: 17'd700,
          source_width: 16'd65535, source_height: 16'd400,
          scale_x: 25'd16777215, scale_y: 25'd5592405},
        '{offset_x: 25'd0, offset_y: 25'd0, map_width: 17'd1, map_height: 17'd1,
          source_width: 16'd1, source_height: 16'd1,
          scale_x: 25'd16777216, scale_y: 25'd16777216}
    };

    function automatic logic [15:0] pick_map_coord(int src);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return UNMAPPED;
        if (sel < 5 || src == 0) return 16'($urandom_range(src, 65535));
        if (sel < 6) return 16'($urandom);
        return 16'($urandom_range(0, src - 1));
    endfunction

    function automatic logic [15:0] pick_pixel(int span);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 2) return 16'($urandom);
        if (sel == 2) return 16'(span - 1);
        return 16'($urandom_range(0, (span > 1024 ? 1024 : span) - 1));
    endfunction

    function automatic t_item random_word();
        t_item it;
        int    sel;
        sel = $urandom_range(0, 99);
        it = '0;
        it.map_x = 16'($urandom);
        it.map_y = 16'($urandom);
        if (sel < 2) begin
            it.op = OP_CLEAR;
        end else if (sel < 5) begin
            it.op = OP_FOOT;
        end else if (sel < 55) begin
            it.op    = OP_REMAP;
            it.col   = pick_pixel(int'(cur_cfg.map_width));
            it.row   = pick_pixel(int'(cur_cfg.map_height));
            it.map_x = pick_map_coord(int'(cur_cfg.source_width));
            it.map_y = pick_map_coord(int'(cur_cfg.source_height));
            // keep some pixels fully mapped so both branches are seen
            if ($urandom_range(0, 3) == 0 && cur_cfg.source_width != 0
                    && cur_cfg.source_height != 0) begin
                it.map_x = 16'($urandom_range(0, int'(cur_cfg.source_width) - 1));
                it.map_y = 16'($urandom_range(0, int'(cur_cfg.source_height) - 1));
            end
        end else begin
            it.op = OP_READ;
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                // near the last knocked-out cell
                it.col = 16'(last_cx + $urandom_range(0, 2) - 1);
                it.row = 16'(last_cy + $urandom_range(0, 2) - 1);
            end else if (sel < 9) begin
                it.col = 16'($urandom_range(0, MASK_COLS - 1));
                it.row = 16'($urandom_range(0, MASK_ROWS - 1));
            end else begin
                it.col = 16'($urandom);
                it.row = 16'($urandom);
            end
        end
        return it;
    endfunction

    initial begin
        t_item it;
        int    n_random;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cur_cfg = '{offset_x: 25'd0, offset_y: 25'd0, map_width: 17'd1, map_height: 17'd1,
                    source_width: 16'd1, source_height: 16'd1,
                    scale_x: 25'd16777216, scale_y: 25'd16777216};
        mask_fill();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset placement
        foreach (directed[k]) begin
            it.op    = directed[k].op;
            it.col   = directed[k].col;
            it.row   = directed[k].row;
            it.map_x = directed[k].mx;
            it.map_y = directed[k].my;
            send_word(it, directed[k].typed, directed[k].val);
        end

        // random part, one block per placement
        n_random = 0;
        foreach (placements[p]) begin
            drain_reads();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            load_placement(placements[p]);
            for (int k = 0; k < 220; k++) begin
                calm_tx = ((n_random / 90) % 4) == 3;
                calm_rx = ((n_random / 70) % 5) == 2;
                // one pause mid-block: hold until the mask reads are all back
                if (k == 110) drain_reads();
                send_word(random_word(), 1'b0, 1'b0);
                n_random++;
            end
        end
        s_tvalid <= 1'b0;

        while (valid_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (valid_expected.size() != 0) begin
            $error("cell_valid: %0d words never arrived", valid_expected.size());
            fails++;
        end
        $display("covered %0d placements, %0d mask reads, %0d remap pixels, %0d mask passes",
                 placements.size() + 1, reads_checked, remaps_sent, passes_sent);
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
